>>> hdl/hamming_sec_codec_macros.svh
// ----------------------------------------------------------------------------
// Hamming SEC codec assertion macros
// Shared concurrent assertion forms for the codec RTL.
// ----------------------------------------------------------------------------
`ifndef HAMMING_SEC_CODEC_MACROS_SVH
`define HAMMING_SEC_CODEC_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HSC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define HSC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/hsc_pkg.sv
// ----------------------------------------------------------------------------
// Hamming SEC codec package
// Word types, codes and the bit placement functions of the codec.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hsc_pkg;

  localparam int MAX_DATA_BITS = 26;
  localparam int CW_W          = 31;
  localparam int SYN_W         = 5;
  localparam int LEN_W         = 5;
  localparam int CHK_BITS      = 5;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_CORRECTED    = 2'd1,
    ST_OUT_OF_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic              operation;
    logic [CW_W-1:0]   word_in;
  } hsc_req_t;

  typedef struct packed {
    logic [CW_W-1:0]   codeword_out;
    logic [SYN_W-1:0]  syndrome;
    status_t           status;
  } hsc_res_t;

  // Second pipeline stage contents handed to the correction stage.
  typedef struct packed {
    logic              valid;
    logic              operation;
    logic [CW_W-1:0]   cw;
    logic [SYN_W-1:0]  syn;
    logic [LEN_W-1:0]  n;
  } hsc_stage_t;

  // Effective data length: zero reads as one, large values saturate.
  function automatic logic [LEN_W-1:0] eff_len(logic [LEN_W-1:0] dl);
    logic [LEN_W-1:0] m;
    m = dl;
    if (m == '0) m = LEN_W'(1);
    if (m > LEN_W'(MAX_DATA_BITS)) m = LEN_W'(MAX_DATA_BITS);
    return m;
  endfunction

  // Codeword length n = m + r, r the smallest count with 2^r >= m + r + 1.
  function automatic logic [LEN_W-1:0] code_len(logic [LEN_W-1:0] m);
    logic [2:0] r;
    r = 3'd6;
    for (int i = 6; i >= 0; i--) begin
      if ((1 << i) >= int'(m) + i + 1) r = 3'(i);
    end
    return LEN_W'(int'(m) + int'(r));
  endfunction

  function automatic logic [CW_W-1:0] cw_mask(logic [LEN_W-1:0] n);
    logic [CW_W-1:0] k;
    for (int p = 1; p <= CW_W; p++) k[p-1] = (p <= int'(n));
    return k;
  endfunction

  function automatic logic [MAX_DATA_BITS-1:0] data_mask(logic [LEN_W-1:0] m);
    logic [MAX_DATA_BITS-1:0] k;
    for (int j = 0; j < MAX_DATA_BITS; j++) k[j] = (j < int'(m));
    return k;
  endfunction

  // Data bits fill the non power-of-two positions in ascending order.
  function automatic logic [CW_W-1:0] scatter(logic [MAX_DATA_BITS-1:0] d);
    logic [CW_W-1:0] w;
    int j;
    w = '0;
    j = 0;
    for (int p = 1; p <= CW_W; p++) begin
      if ((p & (p - 1)) != 0) begin
        if (j < MAX_DATA_BITS) w[p-1] = d[j];
        j++;
      end
    end
    return w;
  endfunction

  // XOR of the positions of all set bits.
  function automatic logic [SYN_W-1:0] syndrome_of(logic [CW_W-1:0] w);
    logic [SYN_W-1:0] s;
    s = '0;
    for (int p = 1; p <= CW_W; p++) begin
      if (w[p-1]) s = s ^ SYN_W'(p);
    end
    return s;
  endfunction

endpackage

>>> hdl/hsc_correct.sv
// ----------------------------------------------------------------------------
// Hamming SEC codec correction stage
// Inserts check bits or flips the named bit, and registers the result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hamming_sec_codec_macros.svh"

module hsc_correct
  import hsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  hsc_stage_t stage,
  output logic       done,
  output hsc_res_t   result
);

  hsc_res_t res_next;

  always_comb begin
    res_next.codeword_out = stage.cw;
    res_next.syndrome     = '0;
    res_next.status       = ST_OK;
    if (stage.operation == OP_ENCODE) begin
      // Check positions are empty here, so the syndrome is the check bits.
      for (int i = 0; i < CHK_BITS; i++) begin
        res_next.codeword_out[(1 << i) - 1] = stage.syn[i];
      end
    end else begin
      res_next.syndrome = stage.syn;
      if (stage.syn == '0) begin
        res_next.status = ST_OK;
      end else if (stage.syn <= stage.n) begin
        res_next.codeword_out = stage.cw ^ (CW_W'(1) << SYN_W'(stage.syn - SYN_W'(1)));
        res_next.status       = ST_CORRECTED;
      end else begin
        res_next.status = ST_OUT_OF_RANGE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage.valid;
    end
    result <= res_next;
  end

  `HSC_ASSERT_IMP(a_ok_no_syn, clk, rst, done && result.status == ST_OK,
    (result.syndrome == '0), "status OK with a nonzero syndrome")
  `HSC_ASSERT_IMP(a_fix_has_syn, clk, rst, done && result.status == ST_CORRECTED,
    (result.syndrome != '0), "correction reported without a syndrome")
  `HSC_ASSERT_NXT(a_done_follows, clk, rst, stage.valid, done,
    "stage word lost before the output register")

endmodule

>>> hdl/hamming_sec_codec.sv
// ----------------------------------------------------------------------------
// Hamming SEC codec
// Even-parity Hamming encoder and single-error corrector for 1 to 26 data bits.
// ----------------------------------------------------------------------------
//
//   channel   signals                         direction  handshake
//   request   start, busy, request            in         start & !busy
//   result    done, result                    out        done strobe, no stall
//   config    cfg_valid, cfg_ready, cfg_data  in         cfg_valid & cfg_ready
//
// A word is taken in every cycle in which busy is low; its result appears on
// done after it has passed the three register stages: placement and masking,
// the syndrome XOR tree, and check-bit insertion or correction.
// Synchronous reset clears the stage valid bits and restores a data length of
// 26; busy is high and cfg_ready low during reset and in the cycle after it.
// The receiver cannot stall, so the pipeline never stops once running.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hamming_sec_codec_macros.svh"

module hamming_sec_codec
  import hsc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  hsc_req_t         request,
  output logic             done,
  output hsc_res_t         result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_data
);

  // Effective data length and codeword length are kept precomputed, so the
  // first stage only has to do masking and placement.
  logic [LEN_W-1:0] len_m;
  logic [LEN_W-1:0] len_n;
  logic             accept;
  logic [CW_W-1:0]  cw_pre;

  // Stage one registers.
  logic             s1_valid;
  logic             s1_op;
  logic [CW_W-1:0]  s1_cw;
  logic [LEN_W-1:0] s1_n;

  hsc_stage_t       s2;

  assign accept    = start && !busy;
  assign cfg_ready = !busy;

  // Busy covers reset and the cycle right after it; afterwards every cycle
  // is open to a new word.
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len_m <= LEN_W'(MAX_DATA_BITS);
      len_n <= code_len(LEN_W'(MAX_DATA_BITS));
    end else if (cfg_valid && cfg_ready) begin
      len_m <= eff_len(cfg_data);
      len_n <= code_len(eff_len(cfg_data));
    end
  end

  // Encoding drops data bits at or above m and spreads the rest over the
  // non power-of-two positions. Decoding just drops bits past position n.
  always_comb begin
    if (request.operation == OP_ENCODE) begin
      cw_pre = scatter(request.word_in[MAX_DATA_BITS-1:0] & data_mask(len_m));
    end else begin
      cw_pre = request.word_in & cw_mask(len_n);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_op <= request.operation;
    s1_cw <= cw_pre;
    s1_n  <= len_n;
  end

  // The syndrome tree runs on the masked word; for an encode it yields the
  // check bits directly since their positions are still clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else begin
      s2.valid <= s1_valid;
    end
    s2.operation <= s1_op;
    s2.cw        <= s1_cw;
    s2.syn       <= syndrome_of(s1_cw);
    s2.n         <= s1_n;
  end

  hsc_correct u_correct (
    .clk    (clk),
    .rst    (rst),
    .stage  (s2),
    .done   (done),
    .result (result)
  );

  `HSC_ASSERT_NXT(a_accept_s1, clk, rst, accept, s1_valid,
    "accepted word missing from stage one")
  `HSC_ASSERT_IMP(a_accept_done, clk, rst, accept, ##3 done,
    "accepted word did not reach the result port in three cycles")
  `HSC_ASSERT_IMP(a_len_range, clk, rst, s2.valid, (s2.n >= LEN_W'(3)),
    "codeword length below the smallest code")

endmodule
